/* rtl/mapool_pkg.sv */
// Shared types and constants for the max / average pooling block.
// Used by mapool_ctrl, mapool_dp and max_avg_pooling_hwc_top.
`default_nettype none

package mapool_pkg;

    // configuration port
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 13;

    // register field widths
    localparam int CH_REG_BITS   = 7;
    localparam int H_REG_BITS    = 13;
    localparam int W_REG_BITS    = 9;
    localparam int K_REG_BITS    = 4;

    // frame height limit and row counter width
    localparam int MAX_HEIGHT    = 4096;
    localparam int ROW_BITS      = 12;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_CHANNELS  = 3'd0,
        REG_HEIGHT    = 3'd1,
        REG_WIDTH     = 3'd2,
        REG_WINDOW    = 3'd3,
        REG_POOL_MODE = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RMW,
        ST_DIV,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // input beat taken, start accumulator read
        logic rmw;        // combine and write back
        logic div_start;  // load divider from combined sum
        logic div_step;   // one quotient bit
        logic load_out;   // move result into output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic active;     // sample belongs to a whole window
        logic last;       // last sample of its window
        logic avg;        // average mode
        logic div_done;
        logic out_free;   // output register can take a result
    } status_t;

endpackage

`default_nettype wire

/* rtl/mapool_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mapool_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 16384
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic                             re,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/mapool_ctrl.sv */
// Sequencing state machine for the pooling block.
// Depends on mapool_pkg (state_t, cmd_t, status_t).
`default_nettype none

module mapool_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire mapool_pkg::status_t status,
    output mapool_pkg::cmd_t        cmd
);

    mapool_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mapool_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mapool_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = mapool_pkg::ST_RMW;
                end
            end
            mapool_pkg::ST_RMW:
            begin
                if (status.active && status.last)
                begin
                    state_next = status.avg ? mapool_pkg::ST_DIV : mapool_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = mapool_pkg::ST_IDLE;
                end
            end
            mapool_pkg::ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = mapool_pkg::ST_EMIT;
                end
            end
            mapool_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = mapool_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mapool_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready       = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            mapool_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            mapool_pkg::ST_RMW:
            begin
                cmd.rmw       = 1'b1;
                cmd.div_start = status.active && status.last && status.avg;
            end
            mapool_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            mapool_pkg::ST_EMIT:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/mapool_dp.sv */
// Datapath: config registers, position counters, accumulator RAM,
// serial divider and output register. Depends on mapool_pkg, mapool_ram.
`default_nettype none

module mapool_dp #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_CHANNELS = 64,
    parameter int MAX_WINDOW   = 8,
    parameter int SAMPLE_BITS  = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [mapool_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  wire logic [mapool_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    input  wire logic signed [SAMPLE_BITS-1:0]         sample,
    input  wire mapool_pkg::cmd_t                      cmd,
    output mapool_pkg::status_t                        status,
    input  wire logic                                  m_tready,
    output logic                                       m_tvalid,
    output logic signed [SAMPLE_BITS-1:0]              pooled_value,
    output logic                                       frame_done
);

    localparam int ACC_BITS  = SAMPLE_BITS + $clog2(MAX_WINDOW * MAX_WINDOW);
    localparam int DEPTH     = MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COL_BITS  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CH_BITS   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int WIN_BITS  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CU_BITS   = $clog2(MAX_CHANNELS + 1);
    localparam int WU_BITS   = $clog2(MAX_WIDTH + 1);
    localparam int KU_BITS   = $clog2(MAX_WINDOW + 1);
    localparam int D_BITS    = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int CS_BITS   = COL_BITS + KU_BITS + 2;
    localparam int RS_BITS   = mapool_pkg::H_REG_BITS + KU_BITS + 2;
    localparam int DCNT_BITS = $clog2(ACC_BITS + 1);

    // ---------------- configuration ----------------
    logic [mapool_pkg::CH_REG_BITS-1:0] ch_cfg_reg;
    logic [mapool_pkg::H_REG_BITS-1:0]  h_cfg_reg;
    logic [mapool_pkg::W_REG_BITS-1:0]  w_cfg_reg;
    logic [mapool_pkg::K_REG_BITS-1:0]  k_cfg_reg;
    logic                               mode_reg;
    logic                               cfg_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_cfg_reg <= mapool_pkg::CH_REG_BITS'(1);
            h_cfg_reg  <= mapool_pkg::H_REG_BITS'(1);
            w_cfg_reg  <= mapool_pkg::W_REG_BITS'(1);
            k_cfg_reg  <= mapool_pkg::K_REG_BITS'(2);
            mode_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                mapool_pkg::REG_CHANNELS:
                    ch_cfg_reg <= cfg_wdata[mapool_pkg::CH_REG_BITS-1:0];
                mapool_pkg::REG_HEIGHT:
                    h_cfg_reg  <= cfg_wdata[mapool_pkg::H_REG_BITS-1:0];
                mapool_pkg::REG_WIDTH:
                    w_cfg_reg  <= cfg_wdata[mapool_pkg::W_REG_BITS-1:0];
                mapool_pkg::REG_WINDOW:
                    k_cfg_reg  <= cfg_wdata[mapool_pkg::K_REG_BITS-1:0];
                mapool_pkg::REG_POOL_MODE:
                    mode_reg   <= cfg_wdata[0];
                default:
                    mode_reg   <= mode_reg;
            endcase
        end
    end

    // a write to a listed register restarts the frame
    assign cfg_hit = cfg_we && (cfg_addr == mapool_pkg::REG_CHANNELS ||
                                cfg_addr == mapool_pkg::REG_HEIGHT ||
                                cfg_addr == mapool_pkg::REG_WIDTH ||
                                cfg_addr == mapool_pkg::REG_WINDOW ||
                                cfg_addr == mapool_pkg::REG_POOL_MODE);

    // clamped values in use
    logic [CU_BITS-1:0]                c_use;
    logic [WU_BITS-1:0]                w_use;
    logic [KU_BITS-1:0]                k_use;
    logic [mapool_pkg::H_REG_BITS-1:0] h_use;
    logic [D_BITS-1:0]                 kk;

    always_comb
    begin
        if (ch_cfg_reg == '0)
            c_use = CU_BITS'(1);
        else if (int'(ch_cfg_reg) > MAX_CHANNELS)
            c_use = CU_BITS'(MAX_CHANNELS);
        else
            c_use = CU_BITS'(ch_cfg_reg);

        if (w_cfg_reg == '0)
            w_use = WU_BITS'(1);
        else if (int'(w_cfg_reg) > MAX_WIDTH)
            w_use = WU_BITS'(MAX_WIDTH);
        else
            w_use = WU_BITS'(w_cfg_reg);

        if (k_cfg_reg == '0)
            k_use = KU_BITS'(1);
        else if (int'(k_cfg_reg) > MAX_WINDOW)
            k_use = KU_BITS'(MAX_WINDOW);
        else
            k_use = KU_BITS'(k_cfg_reg);

        if (h_cfg_reg == '0)
            h_use = mapool_pkg::H_REG_BITS'(1);
        else if (int'(h_cfg_reg) > mapool_pkg::MAX_HEIGHT)
            h_use = mapool_pkg::H_REG_BITS'(mapool_pkg::MAX_HEIGHT);
        else
            h_use = h_cfg_reg;
    end

    assign kk = D_BITS'(k_use * k_use);

    // ---------------- position counters ----------------
    logic [CH_BITS-1:0]             ch_reg, ch_next;
    logic [COL_BITS-1:0]            col_reg, col_next;
    logic [WIN_BITS-1:0]            ciw_reg, ciw_next;
    logic [COL_BITS-1:0]            ocol_reg, ocol_next;
    logic [CS_BITS-1:0]             col_start_reg, col_start_next;
    logic [mapool_pkg::ROW_BITS-1:0] row_reg, row_next;
    logic [WIN_BITS-1:0]            riw_reg, riw_next;
    logic [RS_BITS-1:0]             row_start_reg, row_start_next;

    logic ch_last, col_last, ciw_last, row_last, riw_last;
    logic col_fit, row_fit, col_final, row_final;
    logic win_first, win_last, frame_last;
    logic [ADDR_BITS-1:0] addr;

    assign ch_last  = ch_reg == CH_BITS'(c_use - 1'b1);
    assign col_last = col_reg == COL_BITS'(w_use - 1'b1);
    assign ciw_last = ciw_reg == WIN_BITS'(k_use - 1'b1);
    assign row_last = row_reg == mapool_pkg::ROW_BITS'(h_use - 1'b1);
    assign riw_last = riw_reg == WIN_BITS'(k_use - 1'b1);

    // current window lies inside the map; the next one does not
    assign col_fit   = (col_start_reg + CS_BITS'(k_use)) <= CS_BITS'(w_use);
    assign row_fit   = (row_start_reg + RS_BITS'(k_use)) <= RS_BITS'(h_use);
    assign col_final = (col_start_reg + CS_BITS'({k_use, 1'b0})) > CS_BITS'(w_use);
    assign row_final = (row_start_reg + RS_BITS'({k_use, 1'b0})) > RS_BITS'(h_use);

    assign win_first  = (riw_reg == '0) && (ciw_reg == '0);
    assign win_last   = riw_last && ciw_last;
    assign frame_last = row_final && col_final && ch_last;

    assign addr = ADDR_BITS'(ocol_reg) * ADDR_BITS'(c_use) + ADDR_BITS'(ch_reg);

    always_comb
    begin
        ch_next        = ch_reg;
        col_next       = col_reg;
        ciw_next       = ciw_reg;
        ocol_next      = ocol_reg;
        col_start_next = col_start_reg;
        row_next       = row_reg;
        riw_next       = riw_reg;
        row_start_next = row_start_reg;
        priority if (cfg_hit)
        begin
            ch_next        = '0;
            col_next       = '0;
            ciw_next       = '0;
            ocol_next      = '0;
            col_start_next = '0;
            row_next       = '0;
            riw_next       = '0;
            row_start_next = '0;
        end
        else if (cmd.accept)
        begin
            if (!ch_last)
            begin
                ch_next = ch_reg + 1'b1;
            end
            else
            begin
                ch_next = '0;
                if (col_last)
                begin
                    col_next       = '0;
                    ciw_next       = '0;
                    ocol_next      = '0;
                    col_start_next = '0;
                    if (row_last)
                    begin
                        row_next       = '0;
                        riw_next       = '0;
                        row_start_next = '0;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                        if (riw_last)
                        begin
                            riw_next       = '0;
                            row_start_next = row_start_reg + RS_BITS'(k_use);
                        end
                        else
                        begin
                            riw_next = riw_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                    if (ciw_last)
                    begin
                        ciw_next       = '0;
                        ocol_next      = ocol_reg + 1'b1;
                        col_start_next = col_start_reg + CS_BITS'(k_use);
                    end
                    else
                    begin
                        ciw_next = ciw_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg        <= '0;
            col_reg       <= '0;
            ciw_reg       <= '0;
            ocol_reg      <= '0;
            col_start_reg <= '0;
            row_reg       <= '0;
            riw_reg       <= '0;
            row_start_reg <= '0;
        end
        else
        begin
            ch_reg        <= ch_next;
            col_reg       <= col_next;
            ciw_reg       <= ciw_next;
            ocol_reg      <= ocol_next;
            col_start_reg <= col_start_next;
            row_reg       <= row_next;
            riw_reg       <= riw_next;
            row_start_reg <= row_start_next;
        end
    end

    // ---------------- beat capture ----------------
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [ADDR_BITS-1:0]          addr_reg;
    logic                          first_reg, last_reg, flast_reg;
    logic                          active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            first_reg  <= 1'b0;
            last_reg   <= 1'b0;
            flast_reg  <= 1'b0;
        end
        else if (cmd.accept)
        begin
            active_reg <= col_fit && row_fit;
            first_reg  <= win_first;
            last_reg   <= win_last;
            flast_reg  <= frame_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= sample;
            addr_reg   <= addr;
        end
    end

    // ---------------- accumulator read-modify-write ----------------
    logic [ACC_BITS-1:0]        rd_data;
    logic signed [ACC_BITS-1:0] acc_old, samp_ext, acc_new;
    logic signed [ACC_BITS-1:0] acc_reg;

    mapool_ram #(
        .WIDTH (ACC_BITS),
        .DEPTH (DEPTH)
    ) u_acc_ram (
        .clk   (clk),
        .we    (cmd.rmw && active_reg),
        .waddr (addr_reg),
        .wdata (acc_new),
        .re    (cmd.accept),
        .raddr (addr),
        .rdata (rd_data)
    );

    assign acc_old  = $signed(rd_data);
    assign samp_ext = ACC_BITS'(sample_reg);

    always_comb
    begin
        if (first_reg)
            acc_new = samp_ext;
        else if (!mode_reg)
            acc_new = (acc_old > samp_ext) ? acc_old : samp_ext;
        else
            acc_new = acc_old + samp_ext;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rmw)
        begin
            acc_reg <= acc_new;
        end
    end

    // ---------------- serial divider (sum / K*K, toward zero) ----------------
    logic [ACC_BITS-1:0]  quo_reg, quo_next;
    logic [D_BITS-1:0]    rem_reg, rem_next;
    logic [DCNT_BITS-1:0] dcnt_reg, dcnt_next;
    logic                 neg_reg, neg_next;
    logic [D_BITS:0]      trial;

    assign trial = {rem_reg, quo_reg[ACC_BITS-1]};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dcnt_next = dcnt_reg;
        neg_next  = neg_reg;
        if (cmd.div_start)
        begin
            neg_next  = acc_new[ACC_BITS-1];
            quo_next  = acc_new[ACC_BITS-1] ? ACC_BITS'(-acc_new) : ACC_BITS'(acc_new);
            rem_next  = '0;
            dcnt_next = DCNT_BITS'(ACC_BITS);
        end
        else if (cmd.div_step && dcnt_reg != '0)
        begin
            dcnt_next = dcnt_reg - 1'b1;
            if (trial >= {1'b0, kk})
            begin
                rem_next = D_BITS'(trial - {1'b0, kk});
                quo_next = {quo_reg[ACC_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = D_BITS'(trial);
                quo_next = {quo_reg[ACC_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else
        begin
            dcnt_reg <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    // ---------------- output register ----------------
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_value_reg;
    logic                          out_last_reg;
    logic [ACC_BITS-1:0]           quo_signed;
    logic signed [SAMPLE_BITS-1:0] result;

    assign quo_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign result     = mode_reg ? SAMPLE_BITS'(quo_signed) : SAMPLE_BITS'(acc_reg);

    always_comb
    begin
        priority if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_value_reg <= result;
            out_last_reg  <= flast_reg;
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign pooled_value = out_value_reg;
    assign frame_done   = out_last_reg;

    assign status.active   = active_reg;
    assign status.last     = last_reg;
    assign status.avg      = mode_reg;
    assign status.div_done = dcnt_reg == '0;
    assign status.out_free = !out_valid_reg || m_tready;

    // ---------------- checks ----------------
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("pending result overwritten");

    a_rmw_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rmw |-> $past(cmd.accept))
        else $error("write-back without a preceding read");

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> (ch_reg == '0 && col_reg == '0 && row_reg == '0 && ocol_reg == '0))
        else $error("config write did not restart the frame");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (CU_BITS'(ch_reg) < c_use) && (WU_BITS'(col_reg) < w_use))
        else $error("position counter beyond configured size");

endmodule

`default_nettype wire

/* rtl/max_avg_pooling_hwc_top.sv */
// Top level of the streaming KxK max / average pooling block.
// Depends on mapool_pkg, mapool_ctrl, mapool_dp (which holds mapool_ram).
`default_nettype none

// Pools a feature map streamed in height, width, channel order (channel
// fastest), KxK windows with stride K, each channel on its own; one pooled
// value leaves per whole window in output row, column, channel order, and
// tlast marks the last value of the frame. Each input beat has its running
// accumulator read from the row RAM when it is accepted and written back
// in the read-modify-write state. A beat that closes a window then passes
// to the emit state in max mode; in average mode it first passes through
// the bit-serial divider for the division by K*K. The result sits in an
// output register, so input keeps flowing while it waits; a further result
// waits only if that register is still full. The accumulator RAM needs no
// clearing: the first sample of each window overwrites its entry. A write
// to any configuration register restarts the frame.
module max_avg_pooling_hwc_top #(
    parameter int MAX_WIDTH    = 256,
    parameter int MAX_CHANNELS = 64,
    parameter int MAX_WINDOW   = 8,
    parameter int SAMPLE_BITS  = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [mapool_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  wire logic [mapool_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // sample
    input  wire logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // pooled_value
    output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0]     m_tdata,
    output logic                                       m_tlast
);

    localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

    mapool_pkg::cmd_t              cmd;
    mapool_pkg::status_t           status;
    logic signed [SAMPLE_BITS-1:0] pooled_value;

    mapool_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mapool_dp #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_WINDOW   (MAX_WINDOW),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .sample       ($signed(s_tdata[SAMPLE_BITS-1:0])),
        .cmd          (cmd),
        .status       (status),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .pooled_value (pooled_value),
        .frame_done   (m_tlast)
    );

    assign m_tdata = TDATA_BITS'($unsigned(pooled_value));

endmodule

`default_nettype wire
